@@ rtl/bblit_pkg.sv @@
`timescale 1ns / 1ps

package bblit_pkg;

	localparam int MAX_IMAGE_DIM     = 1024;
	localparam int DIM_W             = 11;
	localparam int POS_W             = $clog2(MAX_IMAGE_DIM);
	localparam int COL_W             = POS_W + 1;
	localparam int RB_W              = POS_W + 2;
	localparam int CFG_DATA_W        = 11;
	localparam int CFG_IDX_W         = 3;
	localparam int FB_WIDTH_DEF      = 135;
	localparam int FB_HEIGHT_DEF     = 240;
	localparam int PALETTE_DEPTH_DEF = 256;

	typedef enum logic [1:0] {
		REQ_PAL_WRITE = 2'd0,
		REQ_PIXEL     = 2'd1,
		REQ_RESTART   = 2'd2
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_MODE    = 3'd0,
		CFG_IMAGE_WIDTH   = 3'd1,
		CFG_IMAGE_HEIGHT  = 3'd2,
		CFG_ROWS_TOP_DOWN = 3'd3,
		CFG_DEST_X        = 3'd4,
		CFG_DEST_Y        = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                     pixel_mode;
		logic                     rows_top_down;
		logic [DIM_W-1:0]         width;
		logic [DIM_W-1:0]         height;
		logic [POS_W-1:0]         width_m1;
		logic [POS_W-1:0]         height_m1;
		logic [RB_W-1:0]          row_bytes;
		logic signed [DIM_W-1:0]  dest_x;
		logic signed [DIM_W-1:0]  dest_y;
	} cfg_t;

	typedef struct packed {
		logic             mode16;
		logic             pal_ok;
		logic             last;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [15:0]      color16;
	} pix_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_IMAGE_DIM))
			r = DIM_W'(MAX_IMAGE_DIM);
		else
			r = v;
		return r;
	endfunction

	// BGRA word to RGB565
	function automatic logic [15:0] to_rgb565(input logic [31:0] word);
		return {word[23:19], word[15:10], word[7:3]};
	endfunction

	function automatic logic [15:0] swap16(input logic [15:0] c);
		return {c[7:0], c[15:8]};
	endfunction

endpackage

@@ rtl/bblit_if.sv @@
`timescale 1ns / 1ps

interface bblit_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  pal_slot;
	logic [31:0] palette_word;
	logic [7:0]  data_byte;

	modport source (output valid, req_type, pal_slot, palette_word, data_byte,
		input ready);
	modport sink (input valid, req_type, pal_slot, palette_word, data_byte,
		output ready);
endinterface

interface bblit_out_if #(parameter int ADDR_W = 15);
	logic              valid;
	logic              ready;
	logic              write_enable;
	logic [ADDR_W-1:0] fb_address;
	logic [15:0]       pixel_color;
	logic              last_pixel;

	modport source (output valid, write_enable, fb_address, pixel_color, last_pixel,
		input ready);
	modport sink (input valid, write_enable, fb_address, pixel_color, last_pixel,
		output ready);
endinterface

@@ rtl/bmp_to_rgb565_blitter_unit.sv @@
`timescale 1ns / 1ps
// A pixel request is registered into stage 1, then into the result stage. Throughput:
// one request per cycle unless stalled; the palette RAM read port and the counter update
// both complete in the accept cycle, and the address multiply sits in the result stage.
// Reset: counters, hold byte, pipeline valids and configuration go to their reset values
// at once; the palette RAM is not cleared and holds nothing meaningful until written.

module bmp_to_rgb565_blitter_unit #(
	parameter int FB_WIDTH      = bblit_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT     = bblit_pkg::FB_HEIGHT_DEF,
	parameter int PALETTE_DEPTH = bblit_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bblit_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bblit_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	bblit_in_if.sink                          item,
	bblit_out_if.source                       result
);

	localparam int FB_SIZE = FB_WIDTH * FB_HEIGHT;
	localparam int ADDR_W  = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1;
	localparam int AW1     = ADDR_W + 1;

	bblit_pkg::cfg_t  cfg;
	logic             valid_s1;
	bblit_pkg::pix_t  pix_s1;
	logic [15:0]      pal_s1;
	logic             s1_ready;

	bblit_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bblit_front #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg      (cfg),
		.s1_ready (s1_ready),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1),
		.pal_s1   (pal_s1)
	);

	bblit_back #(
		.FB_WIDTH  (FB_WIDTH),
		.FB_HEIGHT (FB_HEIGHT),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1),
		.pal_s1   (pal_s1),
		.cfg      (cfg),
		.s1_ready (s1_ready),
		.result   (result)
	);

	a_clip_addr: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.write_enable |-> result.fb_address == '0)
		else $error("clipped pixel with non-zero address");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.write_enable |->
			AW1'(result.fb_address) < AW1'(FB_SIZE))
		else $error("frame buffer address out of range");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.req_type != bblit_pkg::REQ_PIXEL |=> !valid_s1)
		else $error("non-pixel request produced a pixel");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_ready |=> valid_s1 && $stable(pix_s1))
		else $error("stalled pixel lost or changed");

endmodule

@@ rtl/bblit_cfg.sv @@
`timescale 1ns / 1ps

module bblit_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bblit_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bblit_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output bblit_pkg::cfg_t                     cfg
);

	localparam int DIM_W = bblit_pkg::DIM_W;
	localparam int POS_W = bblit_pkg::POS_W;
	localparam int RB_W  = bblit_pkg::RB_W;

	logic             pixel_mode_q;
	logic             top_down_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] dest_x_q;
	logic [DIM_W-1:0] dest_y_q;

	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [RB_W-1:0]  rb_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= 1'b0;
			top_down_q   <= 1'b0;
			width_q      <= DIM_W'(1);
			height_q     <= DIM_W'(1);
			dest_x_q     <= '0;
			dest_y_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bblit_pkg::CFG_PIXEL_MODE:    pixel_mode_q <= cfg_wdata[0];
				bblit_pkg::CFG_IMAGE_WIDTH:   width_q      <= DIM_W'(cfg_wdata);
				bblit_pkg::CFG_IMAGE_HEIGHT:  height_q     <= DIM_W'(cfg_wdata);
				bblit_pkg::CFG_ROWS_TOP_DOWN: top_down_q   <= cfg_wdata[0];
				bblit_pkg::CFG_DEST_X:        dest_x_q     <= DIM_W'(cfg_wdata);
				bblit_pkg::CFG_DEST_Y:        dest_y_q     <= DIM_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		w = bblit_pkg::clamp_dim(width_q);
		h = bblit_pkg::clamp_dim(height_q);
		// rows padded to a multiple of four bytes
		if (pixel_mode_q)
			rb_raw = RB_W'({w, 1'b0}) + RB_W'(3);
		else
			rb_raw = RB_W'(w) + RB_W'(3);
		cfg.pixel_mode    = pixel_mode_q;
		cfg.rows_top_down = top_down_q;
		cfg.width         = w;
		cfg.height        = h;
		cfg.width_m1      = POS_W'(w - DIM_W'(1));
		cfg.height_m1     = POS_W'(h - DIM_W'(1));
		cfg.row_bytes     = {rb_raw[RB_W-1:2], 2'b00};
		cfg.dest_x        = dest_x_q;
		cfg.dest_y        = dest_y_q;
	end

endmodule

@@ rtl/bblit_front.sv @@
`timescale 1ns / 1ps

module bblit_front #(
	parameter int PALETTE_DEPTH = bblit_pkg::PALETTE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bblit_in_if.sink           item,
	input  bblit_pkg::cfg_t    cfg,
	input  logic               s1_ready,
	output logic               valid_s1,
	output bblit_pkg::pix_t    pix_s1,
	output logic [15:0]        pal_s1
);

	localparam int POS_W     = bblit_pkg::POS_W;
	localparam int COL_W     = bblit_pkg::COL_W;
	localparam int RB_W      = bblit_pkg::RB_W;
	localparam int DIM_W     = bblit_pkg::DIM_W;
	localparam int PAL_IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [15:0] pal_mem [PALETTE_DEPTH];

	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [7:0]       hold_q;

	logic             accept;
	logic             is_pixel;
	logic             is_restart;
	logic             is_pal_wr;
	logic             pal_wr_ok;
	logic             pal_rd_ok;
	logic [COL_W-1:0] col_n;
	logic [POS_W-1:0] row_n;
	logic             in_span;
	logic             have_pixel;
	logic             take_low;
	logic [POS_W-1:0] col_pix;
	logic [POS_W-1:0] disp_row;
	logic [RB_W-1:0]  col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             row_wrap;
	logic [COL_W-1:0] col_next;
	logic [POS_W-1:0] row_next;

	assign accept     = item.valid && item.ready;
	assign item.ready = !valid_s1 || s1_ready;
	assign is_pixel   = item.req_type == bblit_pkg::REQ_PIXEL;
	assign is_restart = item.req_type == bblit_pkg::REQ_RESTART;
	assign is_pal_wr  = item.req_type == bblit_pkg::REQ_PAL_WRITE;
	assign pal_wr_ok  = {1'b0, item.pal_slot} < 9'(PALETTE_DEPTH);
	assign pal_rd_ok  = {1'b0, item.data_byte} < 9'(PALETTE_DEPTH);

	always_comb begin
		// stale counters from a larger image fold back to zero
		col_n = (RB_W'(col_q) >= cfg.row_bytes) ? '0 : col_q;
		row_n = (DIM_W'(row_q) >= cfg.height) ? '0 : row_q;

		if (cfg.pixel_mode) begin
			in_span    = RB_W'(col_n) < RB_W'({cfg.width, 1'b0});
			have_pixel = in_span && col_n[0];
			take_low   = in_span && !col_n[0];
			col_pix    = col_n[COL_W-1:1];
		end else begin
			in_span    = DIM_W'(col_n) < cfg.width;
			have_pixel = in_span;
			take_low   = 1'b0;
			col_pix    = POS_W'(col_n);
		end

		disp_row = cfg.rows_top_down ? row_n : (cfg.height_m1 - row_n);

		col_inc  = RB_W'(col_n) + RB_W'(1);
		row_inc  = DIM_W'(row_n) + DIM_W'(1);
		row_wrap = row_inc >= cfg.height;
		if (col_inc >= cfg.row_bytes) begin
			col_next = '0;
			row_next = row_wrap ? '0 : POS_W'(row_inc);
		end else begin
			col_next = COL_W'(col_inc);
			row_next = row_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hold_q <= '0;
		end else if (accept) begin
			if (is_restart) begin
				col_q  <= '0;
				row_q  <= '0;
				hold_q <= '0;
			end else if (is_pixel) begin
				col_q <= col_next;
				row_q <= row_next;
				if (take_low)
					hold_q <= item.data_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pal_wr && pal_wr_ok)
			pal_mem[item.pal_slot[PAL_IDX_W-1:0]] <=
				bblit_pkg::to_rgb565(item.palette_word);
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel)
			pal_s1 <= pal_mem[item.data_byte[PAL_IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item.ready)
			valid_s1 <= accept && is_pixel && have_pixel;
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			pix_s1.mode16  <= cfg.pixel_mode;
			pix_s1.pal_ok  <= pal_rd_ok;
			pix_s1.last    <= (row_n == cfg.height_m1) && (col_pix == cfg.width_m1);
			pix_s1.col     <= col_pix;
			pix_s1.row     <= disp_row;
			// high byte arrives second; swapped order puts the held low byte on top
			pix_s1.color16 <= {hold_q, item.data_byte};
		end
	end

endmodule

@@ rtl/bblit_back.sv @@
`timescale 1ns / 1ps

module bblit_back #(
	parameter int FB_WIDTH  = bblit_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT = bblit_pkg::FB_HEIGHT_DEF,
	parameter int ADDR_W    = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  bblit_pkg::pix_t    pix_s1,
	input  logic [15:0]        pal_s1,
	input  bblit_pkg::cfg_t    cfg,
	output logic               s1_ready,
	bblit_out_if.source        result
);

	localparam int XW = bblit_pkg::DIM_W + 2;
	localparam logic signed [XW-1:0] FBW_S  = XW'(FB_WIDTH);
	localparam logic signed [XW-1:0] FBH_S  = XW'(FB_HEIGHT);
	localparam logic [ADDR_W-1:0]    FBW_A  = ADDR_W'(FB_WIDTH);

	logic              valid_s2;
	logic              we_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [15:0]       color_s2;
	logic              last_s2;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic                 on_fb;
	logic [ADDR_W-1:0]    addr;
	logic [15:0]          color;

	assign s1_ready = !valid_s2 || result.ready;

	always_comb begin
		dx = XW'($signed(cfg.dest_x)) + XW'({1'b0, pix_s1.col});
		dy = XW'($signed(cfg.dest_y)) + XW'({1'b0, pix_s1.row});
		on_fb = !dx[XW-1] && (dx < FBW_S) && !dy[XW-1] && (dy < FBH_S);
		addr = on_fb ? (ADDR_W'(dy) * FBW_A + ADDR_W'(dx)) : '0;
		if (pix_s1.mode16)
			color = pix_s1.color16;
		else if (pix_s1.pal_ok)
			color = bblit_pkg::swap16(pal_s1);
		else
			color = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s1_ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_ready && valid_s1) begin
			we_s2    <= on_fb;
			addr_s2  <= addr;
			color_s2 <= color;
			last_s2  <= pix_s1.last;
		end
	end

	assign result.valid        = valid_s2;
	assign result.write_enable = we_s2;
	assign result.fb_address   = addr_s2;
	assign result.pixel_color  = color_s2;
	assign result.last_pixel   = last_s2;

endmodule

@@ test/bmp_to_rgb565_blitter_unit_check.sv @@
`timescale 1ns / 1ps

module bmp_to_rgb565_blitter_unit_check #(
	parameter int FB_WIDTH      = bblit_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT     = bblit_pkg::FB_HEIGHT_DEF,
	parameter int PALETTE_DEPTH = bblit_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bblit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bblit_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bblit_in_if                              item,
	bblit_out_if                             result,
	output int                               error_count,
	output int                               pending_count,
	output int                               checked_count,
	output int                               frame_count
);

	localparam int DIM_W = bblit_pkg::DIM_W;

	typedef struct packed {
		logic        we;
		logic [14:0] addr;
		logic [15:0] color;
		logic        last;
	} fb_write_t;

	fb_write_t due_writes[$];
	fb_write_t seen, want;

	// shadow of the block's registers and counters
	logic [15:0]             palette [PALETTE_DEPTH];
	logic                    mode16;
	logic                    rows_fwd;
	logic [DIM_W-1:0]        width_raw;
	logic [DIM_W-1:0]        height_raw;
	logic signed [DIM_W-1:0] org_x;
	logic signed [DIM_W-1:0] org_y;
	int                      byte_col;
	int                      row_cnt;
	logic [7:0]              low_hold;

	task automatic report_mismatch(input string what);
		if (error_count < 40)
			$display("%0t ns  MISMATCH  %s", $time, what);
		error_count++;
	endtask

	function automatic int dim_limit(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > bblit_pkg::MAX_IMAGE_DIM)
			return bblit_pkg::MAX_IMAGE_DIM;
		return int'(v);
	endfunction

	// Consumes one pixel-array byte; returns 1 when it completes a pixel.
	function automatic bit blit_byte(input logic [7:0] data, output fb_write_t wr);
		int w, h, row_bytes, col, disp_row, dx, dy;
		bit hit;
		logic [15:0] rgb;
		w = dim_limit(width_raw);
		h = dim_limit(height_raw);
		row_bytes = mode16 ? ((2 * w + 3) / 4) * 4 : ((w + 3) / 4) * 4;
		// counters left over from larger dimensions restart at zero
		if (byte_col >= row_bytes)
			byte_col = 0;
		if (row_cnt >= h)
			row_cnt = 0;
		hit = 1'b0;
		col = 0;
		rgb = '0;
		wr = '0;
		if (!mode16) begin
			if (byte_col < w) begin
				col = byte_col;
				rgb = (int'(data) < PALETTE_DEPTH) ? palette[data] : '0;
				hit = 1'b1;
			end
		end else if (byte_col < 2 * w) begin
			if (byte_col % 2 == 0) begin
				low_hold = data;
			end else begin
				col = byte_col / 2;
				rgb = {data, low_hold};
				hit = 1'b1;
			end
		end
		if (hit) begin
			disp_row = rows_fwd ? row_cnt : h - 1 - row_cnt;
			dx = int'(org_x) + col;
			dy = int'(org_y) + disp_row;
			wr.we = (dx >= 0) && (dx < FB_WIDTH) && (dy >= 0) && (dy < FB_HEIGHT);
			wr.addr = wr.we ? 15'(dy * FB_WIDTH + dx) : '0;
			wr.color = {rgb[7:0], rgb[15:8]};
			wr.last = (row_cnt == h - 1) && (col == w - 1);
		end
		byte_col++;
		if (byte_col >= row_bytes) begin
			byte_col = 0;
			row_cnt++;
			if (row_cnt >= h)
				row_cnt = 0;
		end
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode16 = 1'b0;
			rows_fwd = 1'b0;
			width_raw = DIM_W'(1);
			height_raw = DIM_W'(1);
			org_x = '0;
			org_y = '0;
			byte_col = 0;
			row_cnt = 0;
			low_hold = '0;
			due_writes.delete();
			error_count = 0;
			checked_count = 0;
			frame_count = 0;
		end else begin
			if (cfg_we) begin
				case (bblit_pkg::cfg_reg_t'(cfg_index))
					bblit_pkg::CFG_PIXEL_MODE:    mode16 = cfg_wdata[0];
					bblit_pkg::CFG_IMAGE_WIDTH:   width_raw = cfg_wdata[DIM_W-1:0];
					bblit_pkg::CFG_IMAGE_HEIGHT:  height_raw = cfg_wdata[DIM_W-1:0];
					bblit_pkg::CFG_ROWS_TOP_DOWN: rows_fwd = cfg_wdata[0];
					bblit_pkg::CFG_DEST_X:        org_x = cfg_wdata[DIM_W-1:0];
					bblit_pkg::CFG_DEST_Y:        org_y = cfg_wdata[DIM_W-1:0];
					default: ;
				endcase
			end
			// results never belong to a request accepted at the same edge
			if (result.valid && result.ready) begin
				seen = {result.write_enable, result.fb_address, result.pixel_color,
					result.last_pixel};
				if (due_writes.size() == 0) begin
					report_mismatch($sformatf({"pixel write with none outstanding:",
						" we=%0b addr=%0d colour=%04h last=%0b"},
						seen.we, seen.addr, seen.color, seen.last));
				end else begin
					want = due_writes.pop_front();
					checked_count++;
					if (seen !== want)
						report_mismatch($sformatf({"pixel write %0d: got we=%0b addr=%0d",
							" colour=%04h last=%0b, want we=%0b addr=%0d colour=%04h last=%0b"},
							checked_count,
							seen.we, seen.addr, seen.color, seen.last,
							want.we, want.addr, want.color, want.last));
					else if (want.last)
						frame_count++;
				end
			end
			if (item.valid && item.ready) begin
				case (bblit_pkg::req_type_t'(item.req_type))
					bblit_pkg::REQ_PAL_WRITE: begin
						if (int'(item.pal_slot) < PALETTE_DEPTH)
							palette[item.pal_slot] = {item.palette_word[23:19],
								item.palette_word[15:10], item.palette_word[7:3]};
					end
					bblit_pkg::REQ_PIXEL: begin
						if (blit_byte(item.data_byte, want))
							due_writes.push_back(want);
					end
					bblit_pkg::REQ_RESTART: begin
						byte_col = 0;
						row_cnt = 0;
						low_hold = '0;
					end
					default: ;
				endcase
			end
		end
		pending_count = due_writes.size();
	end

endmodule

@@ test/bmp_to_rgb565_blitter_unit_tb.sv @@
`timescale 1ns / 1ps

module bmp_to_rgb565_blitter_unit_tb;

	localparam logic [1:0] REQ_UNUSED     = 2'd3;
	localparam int         REQUEST_TARGET = 1450;
	localparam int         STALL_LIMIT    = 2000;
	localparam int         CFG_DATA_W     = bblit_pkg::CFG_DATA_W;
	localparam int         MAX_DIM        = bblit_pkg::MAX_IMAGE_DIM;
	localparam int         PAL_DEPTH      = bblit_pkg::PALETTE_DEPTH_DEF;
	localparam int         FB_W           = bblit_pkg::FB_WIDTH_DEF;
	localparam int         FB_H           = bblit_pkg::FB_HEIGHT_DEF;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_we;
	logic [bblit_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]             cfg_wdata;

	int error_count, pending_count, checked_count, frame_count;
	int requests_sent = 0;
	int settings_applied = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	bblit_in_if  item_bus();
	bblit_out_if result_bus();

	bmp_to_rgb565_blitter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_bus),
		.result    (result_bus)
	);

	bmp_to_rgb565_blitter_unit_check write_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.item          (item_bus),
		.result        (result_bus),
		.error_count   (error_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.frame_count   (frame_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, the odd long one; none at all while calm
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (calm || roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 15);
	endfunction

	function automatic int eff_dim(input int v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic int odd_dim();
		case ($urandom_range(4))
			0: return 0;
			1: return MAX_DIM;
			2: return MAX_DIM + 1;
			3: return 2047;
			default: return $urandom_range(2047);
		endcase
	endfunction

	// mostly near the frame buffer so that edges clip, sometimes far out
	function automatic int pick_origin(input int span);
		case ($urandom_range(9))
			0: return -1024;
			1: return 1023;
			2: return int'($urandom_range(2047)) - 1024;
			default: return int'($urandom_range(span + 16)) - 8;
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_bus.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_bus.ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready) ||
				(result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: nothing accepted for %0d cycles, %0d pixel writes outstanding",
				STALL_LIMIT, pending_count);
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_req(input logic [1:0] kind, input logic [7:0] idx,
			input logic [31:0] word, input logic [7:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.req_type <= kind;
		item_bus.pal_slot <= idx;
		item_bus.palette_word <= word;
		item_bus.data_byte <= data;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		if (kind != REQ_UNUSED)
			requests_sent++;
	endtask

	task automatic send_pixel(input logic [7:0] data);
		send_req(bblit_pkg::REQ_PIXEL, 8'($urandom), $urandom, data);
	endtask

	task automatic send_junk(input logic [1:0] kind);
		send_req(kind, 8'($urandom), $urandom, 8'($urandom));
	endtask

	task automatic write_reg(input bblit_pkg::cfg_reg_t idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// registers only change once every pixel write is out and the pipe has settled
	task automatic apply_setting(input bit mode16, input int w, input int h, input bit fwd_rows,
			input int org_x, input int org_y);
		item_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
		repeat (4) @(posedge clk);
		write_reg(bblit_pkg::CFG_PIXEL_MODE, CFG_DATA_W'(mode16));
		write_reg(bblit_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_reg(bblit_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		write_reg(bblit_pkg::CFG_ROWS_TOP_DOWN, CFG_DATA_W'(fwd_rows));
		write_reg(bblit_pkg::CFG_DEST_X, CFG_DATA_W'(org_x));
		write_reg(bblit_pkg::CFG_DEST_Y, CFG_DATA_W'(org_y));
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	initial begin
		int w, h, nbytes, roll;
		bit mode16, big;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bblit_pkg::CFG_PIXEL_MODE;
		cfg_wdata <= '0;
		item_bus.valid <= 1'b0;
		item_bus.req_type <= bblit_pkg::REQ_PAL_WRITE;
		item_bus.pal_slot <= '0;
		item_bus.palette_word <= '0;
		item_bus.data_byte <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole palette first, so any index may be read later
		for (int i = 0; i < PAL_DEPTH; i++)
			send_req(bblit_pkg::REQ_PAL_WRITE, 8'(i),
				(i == 0) ? 32'h0 : (i == PAL_DEPTH - 1) ? 32'hFFFF_FFFF : $urandom(),
				8'($urandom));

		// reset settings: 1x1 8-bit image, one pixel and three padding bytes per row
		send_pixel(8'hFF);
		repeat (3) send_pixel(8'($urandom));
		send_pixel(8'h00);
		send_junk(REQ_UNUSED);
		send_junk(bblit_pkg::REQ_RESTART);
		send_pixel(8'h80);

		// 16-bit row of three pixels plus two padding bytes, all clipped
		apply_setting(1'b1, 3, 1, 1'b1, 1023, -1024);
		send_junk(bblit_pkg::REQ_RESTART);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'h34);
		send_pixel(8'h12);
		repeat (2) send_pixel(8'($urandom));

		// zero dimensions act as 1; lands on the last frame-buffer location
		apply_setting(1'b0, 0, 0, 1'b0, FB_W - 1, FB_H - 1);
		send_req(bblit_pkg::REQ_PAL_WRITE, 8'd7, $urandom, 8'($urandom));
		send_pixel(8'd7);
		repeat (3) send_pixel(8'($urandom));

		// oversized dimensions clamp; left edge hangs off the frame buffer
		apply_setting(1'b0, 2047, MAX_DIM + 1, 1'b1, -3, 5);
		repeat (5) send_pixel(8'($urandom));

		while (requests_sent < REQUEST_TARGET) begin
			calm = ($urandom_range(4) == 0);
			mode16 = 1'($urandom_range(1));
			big = ($urandom_range(9) == 0);
			if (big) begin
				w = odd_dim();
				h = odd_dim();
			end else begin
				w = $urandom_range(12, 1);
				h = $urandom_range(6, 1);
			end
			apply_setting(mode16, w, h, 1'($urandom_range(1)), pick_origin(FB_W),
				pick_origin(FB_H));
			// without a restart the counters carry over into the new setting
			if ($urandom_range(9) < 7)
				send_junk(bblit_pkg::REQ_RESTART);
			if (big) begin
				nbytes = $urandom_range(120, 20);
			end else begin
				nbytes = (mode16 ? ((2 * eff_dim(w) + 3) / 4) * 4 : ((eff_dim(w) + 3) / 4) * 4)
					* eff_dim(h);
				if ($urandom_range(4) == 0)
					nbytes = $urandom_range(2 * nbytes, 1);
			end
			for (int k = 0; k < nbytes; k++) begin
				roll = $urandom_range(99);
				if (roll < 4)
					send_junk(bblit_pkg::REQ_PAL_WRITE);
				else if (roll < 6)
					send_junk(REQ_UNUSED);
				else if (roll == 6)
					send_junk(bblit_pkg::REQ_RESTART);
				send_pixel(8'($urandom));
			end
		end

		calm = 1'b0;
		item_bus.valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests under %0d blit settings", requests_sent, settings_applied);
		$display("Checked %0d pixel writes, %0d complete images", checked_count, frame_count);
		if (error_count == 0 && pending_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
